// ===== rtl/core/psie_pkg.sv =====
`default_nettype none

package psie_pkg;

    // width of the side length that the scoring actually uses
    localparam int SIDE_BITS = 10;
    localparam int NUM_SIDES = 6;

    // fixed field widths on the ports
    localparam int VAL_W     = 3;
    localparam int IN_SIDE_W = 10;
    localparam int ALIGN_W   = 3;
    localparam int IRR_W     = 14;
    localparam int OFF_W     = 13;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // internal signed arithmetic width, room for every sum and slack term
    localparam int CALC_W = (SIDE_BITS + 5 > IRR_W + 1) ? SIDE_BITS + 5 : IRR_W + 1;

    localparam logic [VAL_W-1:0] VAL_TRI  = VAL_W'(3);
    localparam logic [VAL_W-1:0] VAL_QUAD = VAL_W'(4);
    localparam logic [VAL_W-1:0] VAL_PENT = VAL_W'(5);
    localparam logic [VAL_W-1:0] VAL_HEX  = VAL_W'(6);

    typedef struct packed {
        logic [VAL_W-1:0]                     valence;
        logic [NUM_SIDES-1:0][SIDE_BITS-1:0]  side;
        logic [ALIGN_W-1:0]                   align_side;
    } psie_item_t;

    typedef struct packed {
        logic [IRR_W-1:0] irregularity;
        logic             is_regular;
        logic             valence_error;
    } psie_score_t;

    typedef struct packed {
        logic [OFF_W-1:0] up_offset;
        logic [OFF_W-1:0] down_offset;
        logic             offsets_valid;
    } psie_offs_t;

    // cyclic side index for elaboration-time loop indices
    function automatic int wrap_idx(input int idx, input int n);
        int r;
        r = idx;
        for (int i = 0; i < 3; i++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psie_score.sv =====
`default_nettype none

module psie_score
    import psie_pkg::*;
(
    input  var psie_item_t  item,
    output var psie_score_t score
);

    localparam logic signed [CALC_W-1:0] ONE     = CALC_W'(1);
    localparam logic signed [CALC_W-1:0] IRR_CAP = CALC_W'((1 << IRR_W) - 1);

    logic signed [CALC_W-1:0] ls [NUM_SIDES];
    logic signed [CALC_W-1:0] sum3;
    logic signed [CALC_W-1:0] sum4;
    logic signed [CALC_W-1:0] sum5;
    logic signed [CALC_W-1:0] sum6;
    logic signed [CALC_W-1:0] sel;
    logic signed [CALC_W-1:0] t;
    logic                     err;

    function automatic logic signed [CALC_W-1:0] clamp_pos(input logic signed [CALC_W-1:0] v);
        return (v > 0) ? v : '0;
    endfunction

    always_comb
    begin
        for (int j = 0; j < NUM_SIDES; j++) begin
            ls[j] = CALC_W'(item.side[j]);
        end

        sum3 = '0;
        sum4 = '0;
        sum5 = '0;
        sum6 = '0;
        t    = '0;

        for (int j = 0; j < 3; j++) begin
            t = ls[j] + ONE - ls[wrap_idx(j + 1, 3)] - ls[wrap_idx(j + 2, 3)];
            sum3 = sum3 + clamp_pos(t);
        end

        // opposite side difference, magnitude
        for (int j = 0; j < 4; j++) begin
            t = ls[j] - ls[wrap_idx(j + 2, 4)];
            sum4 = sum4 + ((t < 0) ? -t : t);
        end

        for (int j = 0; j < 5; j++) begin
            t = ls[j] + ls[wrap_idx(j + 1, 5)] + ONE
                - ls[wrap_idx(j + 2, 5)] - ls[wrap_idx(j + 3, 5)] - ls[wrap_idx(j + 4, 5)];
            sum5 = sum5 + clamp_pos(t);
        end

        // hexagon: parity of alternate sides plus slack
        for (int j = 0; j < 6; j++) begin
            sum6 = sum6 + CALC_W'(item.side[j][0] ^ item.side[wrap_idx(j + 2, 6)][0]
                                  ^ item.side[wrap_idx(j + 4, 6)][0]);
            t = ls[j] + ONE - ls[wrap_idx(j + 2, 6)] - ls[wrap_idx(j + 4, 6)];
            sum6 = sum6 + clamp_pos(t);
        end
    end

    always_comb
    begin
        unique case (item.valence)
            VAL_TRI:
            begin
                sel = sum3;
                err = 1'b0;
            end
            VAL_QUAD:
            begin
                sel = sum4;
                err = 1'b0;
            end
            VAL_PENT:
            begin
                sel = sum5;
                err = 1'b0;
            end
            VAL_HEX:
            begin
                sel = sum6;
                err = 1'b0;
            end
            default:
            begin
                sel = '0;
                err = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        score.irregularity  = (sel > IRR_CAP) ? IRR_CAP[IRR_W-1:0] : sel[IRR_W-1:0];
        score.is_regular    = !err && (sel == '0);
        score.valence_error = err;
    end

endmodule

`default_nettype wire

// ===== rtl/core/psie_offset.sv =====
`default_nettype none

module psie_offset
    import psie_pkg::*;
(
    input  var psie_item_t item,
    output var psie_offs_t offs
);

    localparam logic signed [CALC_W-1:0] OFF_HI = CALC_W'((1 << (OFF_W - 1)) - 1);
    localparam logic signed [CALC_W-1:0] OFF_LO = CALC_W'(-(1 << (OFF_W - 1)));

    logic signed [CALC_W-1:0] ls [NUM_SIDES];
    logic signed [CALC_W-1:0] r3 [5];
    logic signed [CALC_W-1:0] r5 [5];
    logic signed [CALC_W-1:0] r6 [5];
    logic signed [CALC_W-1:0] up;
    logic signed [CALC_W-1:0] down;
    logic                     offv;

    function automatic logic [OFF_W-1:0] sat_off(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] c;
        c = (v > OFF_HI) ? OFF_HI : ((v < OFF_LO) ? OFF_LO : v);
        return c[OFF_W-1:0];
    endfunction

    // sides rotated to start at align_side, taken modulo each valence
    always_comb
    begin
        for (int j = 0; j < NUM_SIDES; j++) begin
            ls[j] = CALC_W'(item.side[j]);
        end
        for (int k = 0; k < 5; k++) begin
            r3[k] = '0;
            r5[k] = '0;
            r6[k] = '0;
        end
        for (int a0 = 0; a0 < (1 << ALIGN_W); a0++) begin
            if (item.align_side == ALIGN_W'(a0)) begin
                for (int k = 0; k < 5; k++) begin
                    r3[k] = ls[wrap_idx(wrap_idx(a0, 3) + k, 3)];
                    r5[k] = ls[wrap_idx(wrap_idx(a0, 5) + k, 5)];
                    r6[k] = ls[wrap_idx(wrap_idx(a0, 6) + k, 6)];
                end
            end
        end
    end

    always_comb
    begin
        unique case (item.valence)
            VAL_TRI:
            begin
                down = r3[0] + r3[2] - r3[1];
                up   = r3[1] + r3[0] - r3[2];
                offv = 1'b1;
            end
            VAL_PENT:
            begin
                down = (r5[0] + r5[1] + r5[2]) - (r5[3] + r5[4]);
                up   = (r5[3] + r5[4] + r5[0]) - (r5[1] + r5[2]);
                offv = 1'b1;
            end
            VAL_HEX:
            begin
                down = r6[0] + r6[2] - r6[4];
                up   = r6[4] + r6[0] - r6[2];
                offv = 1'b1;
            end
            default:
            begin
                down = '0;
                up   = '0;
                offv = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        offs.up_offset     = sat_off(up);
        offs.down_offset   = sat_off(down);
        offs.offsets_valid = offv;
    end

endmodule

`default_nettype wire

// ===== rtl/core/patch_side_irregularity_eval_unit.sv =====
`default_nettype none

// Scores one polygonal patch per word: the irregularity penalty over its sides, the up and
// down singularity offsets seen from align_side, and flags for regular patches, valid offsets
// and unsupported valences. One patch is accepted every cycle unless backpressure reaches the
// input. A word is captured in the input register, scored by combinational logic between the
// input register and the result register, and leaves from the result register. Stalls on the
// output hold both stages and backpressure reaches the input only when both are full.

module patch_side_irregularity_eval_unit
    import psie_pkg::*;
(
    input  var logic                 clk,
    input  var logic                 rst_n,

    input  var logic                 s_tvalid,
    output var logic                 s_tready,
    // valence[2:0], side_len_a..side_len_f[62:3] (10 bits each), align_side[65:63]
    input  var logic [S_TDATA_W-1:0] s_tdata,

    output var logic                 m_tvalid,
    input  var logic                 m_tready,
    // irregularity[13:0], is_regular[14], up_offset[27:15], down_offset[40:28]
    output var logic [M_TDATA_W-1:0] m_tdata,
    // offsets_valid[0], valence_error[1]
    output var logic [M_TUSER_W-1:0] m_tuser
);

    localparam int SIDE_LSB = VAL_W;
    localparam int ALIGN_LSB = VAL_W + NUM_SIDES * IN_SIDE_W;
    localparam int M_USED_W = IRR_W + 1 + 2 * OFF_W;

    psie_item_t  item_in;
    psie_item_t  item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    psie_score_t score;
    psie_offs_t  offs;
    psie_score_t score_reg;
    psie_offs_t  offs_reg;

    always_comb
    begin
        item_in.valence    = s_tdata[VAL_W-1:0];
        item_in.align_side = s_tdata[ALIGN_LSB +: ALIGN_W];
        for (int j = 0; j < NUM_SIDES; j++) begin
            item_in.side[j] = SIDE_BITS'(s_tdata[SIDE_LSB + IN_SIDE_W * j +: IN_SIDE_W]);
        end
    end

    // result stage moves when its slot is empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_in;
        end
        if (advance && in_valid_reg) begin
            score_reg <= score;
            offs_reg  <= offs;
        end
    end

    psie_score u_score (
        .item  (item_reg),
        .score (score)
    );

    psie_offset u_offset (
        .item (item_reg),
        .offs (offs)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, offs_reg.down_offset, offs_reg.up_offset,
                       score_reg.is_regular, score_reg.irregularity};
    assign m_tuser  = {score_reg.valence_error, offs_reg.offsets_valid};

endmodule

`default_nettype wire
